// File: hdl/ctc_pkg.sv
// Shared types and constants for the Collatz trajectory check block.
// Holds the datapath command and flag structs, the controller states and the
// table of powers of three. No dependencies.
`default_nettype none
package ctc_pkg;

    localparam int POW_ENTRIES = 41;
    localparam int POW_CAP     = POW_ENTRIES - 1;
    localparam int A_W         = $clog2(POW_ENTRIES);
    localparam int MUL_STEPS   = 8;
    localparam int MCNT_W      = $clog2(MUL_STEPS + 1);
    localparam int STRIP_W     = 8;
    localparam int ZW          = $clog2(STRIP_W + 1);
    localparam logic [31:0] ROUND_LIMIT_RESET = 32'd1000000;
    localparam logic        REG_ROUND_LIMIT   = 1'b0;

    localparam logic [63:0] POW3_TABLE [POW_ENTRIES] = '{
        64'd1, 64'd3, 64'd9, 64'd27, 64'd81, 64'd243, 64'd729, 64'd2187,
        64'd6561, 64'd19683, 64'd59049, 64'd177147, 64'd531441,
        64'd1594323, 64'd4782969, 64'd14348907, 64'd43046721,
        64'd129140163, 64'd387420489, 64'd1162261467, 64'd3486784401,
        64'd10460353203, 64'd31381059609, 64'd94143178827,
        64'd282429536481, 64'd847288609443, 64'd2541865828329,
        64'd7625597484987, 64'd22876792454961, 64'd68630377364883,
        64'd205891132094649, 64'd617673396283947, 64'd1853020188851841,
        64'd5559060566555523, 64'd16677181699666569,
        64'd50031545098999707, 64'd150094635296999121,
        64'd450283905890997363, 64'd1350851717672992089,
        64'd4052555153018976267, 64'd12157665459056928801
    };

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_LIMIT    = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_INC,
        DP_STRIP_CAP,
        DP_MUL_INIT,
        DP_MUL_STEP,
        DP_MUL_END,
        DP_SUB,
        DP_PEAK,
        DP_STRIP,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic invalid;
        logic limit_hit;
        logic n_ones;
        logic cap_done;
        logic strip_done;
        logic mul_last;
        logic mul_ovf;
        logic acc_even;
        logic below;
    } t_dp_flags;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ROUND,
        S_STRIP_CAP,
        S_MUL,
        S_MUL_END,
        S_SUB,
        S_PEAK,
        S_STRIP,
        S_CMP,
        S_FINISH
    } t_state;

endpackage
`default_nettype wire

// File: hdl/ctc_dp.sv
// Datapath of the Collatz trajectory check: value, peak and count registers,
// strip shifter, serial 128x64 multiplier and output registers.
// Depends on ctc_pkg.
`default_nettype none
module ctc_dp (
    input  wire logic              i_clk,
    input  wire ctc_pkg::t_dp_cmd  i_cmd,
    input  wire logic [31:0]       i_round_limit,
    input  wire logic [63:0]       i_start_low,
    input  wire logic [63:0]       i_start_high,
    output ctc_pkg::t_dp_flags     o_flags,
    output logic [63:0]            o_peak_low,
    output logic [63:0]            o_peak_high,
    output logic [31:0]            o_round_count,
    output logic [1:0]             o_status
);

    logic [127:0]             r_n;
    logic [127:0]             r_n0;
    logic [127:0]             r_peak;
    logic [31:0]              r_count;
    logic [ctc_pkg::A_W-1:0]  r_a;
    logic [63:0]              r_f;
    logic [191:0]             r_acc;
    logic [ctc_pkg::MCNT_W-1:0] r_mcnt;
    logic [63:0]              r_pp;
    logic [2:0]               r_pp_pos;
    logic                     r_pp_vld;
    logic [127:0]             r_out_peak;
    logic [31:0]              r_out_count;
    logic [1:0]               r_out_status;

    logic [ctc_pkg::ZW-1:0]   z;
    logic [ctc_pkg::A_W-1:0]  z_ext;
    logic [ctc_pkg::A_W-1:0]  room;
    logic [ctc_pkg::A_W-1:0]  cap_sh;
    logic [31:0]              a_chunk;
    logic [31:0]              f_chunk;
    logic [2:0]               pos;
    logic [191:0]             acc_add;

    always_comb begin
        z = ctc_pkg::ZW'(ctc_pkg::STRIP_W);
        for (int k = ctc_pkg::STRIP_W - 1; k >= 0; k--) begin
            if (r_n[k]) begin
                z = ctc_pkg::ZW'(k);
            end
        end
    end

    assign z_ext   = ctc_pkg::A_W'(z);
    assign room    = ctc_pkg::A_W'(ctc_pkg::POW_CAP) - r_a;
    assign cap_sh  = (z_ext > room) ? room : z_ext;
    assign a_chunk = r_n[{r_mcnt[1:0], 5'b0} +: 32];
    assign f_chunk = r_f[{r_mcnt[2], 5'b0} +: 32];
    assign pos     = {1'b0, r_mcnt[1:0]} + {2'b0, r_mcnt[2]};
    assign acc_add = {128'b0, r_pp} << {r_pp_pos, 5'b0};

    always_comb begin
        o_flags.invalid    = (r_n0 == 128'd0) || (&r_n0);
        o_flags.limit_hit  = (r_count >= i_round_limit);
        o_flags.n_ones     = &r_n;
        o_flags.cap_done   = r_n[0] || (r_a == ctc_pkg::A_W'(ctc_pkg::POW_CAP));
        o_flags.strip_done = r_n[0] || (r_n == 128'd0);
        o_flags.mul_last   = (r_mcnt == ctc_pkg::MCNT_W'(ctc_pkg::MUL_STEPS));
        o_flags.mul_ovf    = |r_acc[191:128];
        o_flags.acc_even   = !r_acc[0];
        o_flags.below      = (r_n < r_n0);
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            ctc_pkg::DP_LOAD: begin
                r_n0    <= {i_start_high, i_start_low};
                r_n     <= {i_start_high, i_start_low};
                r_peak  <= 128'd0;
                r_count <= 32'd0;
                r_a     <= '0;
            end
            ctc_pkg::DP_INC: begin
                r_n     <= r_n + 128'd1;
                r_count <= r_count + 32'd1;
            end
            ctc_pkg::DP_STRIP_CAP: begin
                r_n <= r_n >> cap_sh;
                r_a <= r_a + cap_sh;
            end
            ctc_pkg::DP_MUL_INIT: begin
                r_f      <= ctc_pkg::POW3_TABLE[r_a];
                r_acc    <= 192'd0;
                r_mcnt   <= '0;
                r_pp_vld <= 1'b0;
            end
            ctc_pkg::DP_MUL_STEP: begin
                if (r_mcnt < ctc_pkg::MCNT_W'(ctc_pkg::MUL_STEPS)) begin
                    r_pp     <= a_chunk * f_chunk;
                    r_pp_pos <= pos;
                    r_pp_vld <= 1'b1;
                end else begin
                    r_pp_vld <= 1'b0;
                end
                if (r_pp_vld) begin
                    r_acc <= r_acc + acc_add;
                end
                r_mcnt <= r_mcnt + ctc_pkg::MCNT_W'(1);
            end
            ctc_pkg::DP_MUL_END: begin
                r_n <= r_acc[127:0];
                r_a <= '0;
            end
            ctc_pkg::DP_SUB: begin
                r_n <= r_n - 128'd1;
            end
            ctc_pkg::DP_PEAK: begin
                if (r_peak < r_n) begin
                    r_peak <= r_n;
                end
            end
            ctc_pkg::DP_STRIP: begin
                r_n <= r_n >> z;
            end
            ctc_pkg::DP_OUT: begin
                r_out_peak   <= r_peak;
                r_out_count  <= r_count;
                r_out_status <= i_cmd.status;
            end
            default: begin
            end
        endcase
    end

    assign o_peak_low    = r_out_peak[63:0];
    assign o_peak_high   = r_out_peak[127:64];
    assign o_round_count = r_out_count;
    assign o_status      = r_out_status;

endmodule
`default_nettype wire

// File: hdl/ctc_ctrl.sv
// Controller state machine of the Collatz trajectory check.
// Sequences the datapath through each round and owns both handshakes.
// Depends on ctc_pkg.
`default_nettype none
module ctc_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  wire ctc_pkg::t_dp_flags  i_flags,
    output ctc_pkg::t_dp_cmd         o_cmd
);

    ctc_pkg::t_state  r_state;
    ctc_pkg::t_state  n_state;
    ctc_pkg::t_status r_code;
    ctc_pkg::t_status n_code;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ctc_pkg::S_IDLE;
            r_code      <= ctc_pkg::ST_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_code       = r_code;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd.op     = ctc_pkg::DP_NOP;
        o_cmd.status = r_code;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ctc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = ctc_pkg::DP_LOAD;
                    n_state  = ctc_pkg::S_CHECK;
                end
            end
            ctc_pkg::S_CHECK: begin
                if (i_flags.invalid) begin
                    n_code  = ctc_pkg::ST_INVALID;
                    n_state = ctc_pkg::S_FINISH;
                end else begin
                    n_state = ctc_pkg::S_ROUND;
                end
            end
            ctc_pkg::S_ROUND: begin
                if (i_flags.limit_hit) begin
                    n_code  = ctc_pkg::ST_LIMIT;
                    n_state = ctc_pkg::S_FINISH;
                end else begin
                    o_cmd.op = ctc_pkg::DP_INC;
                    if (i_flags.n_ones) begin
                        n_code  = ctc_pkg::ST_OVERFLOW;
                        n_state = ctc_pkg::S_FINISH;
                    end else begin
                        n_state = ctc_pkg::S_STRIP_CAP;
                    end
                end
            end
            ctc_pkg::S_STRIP_CAP: begin
                if (i_flags.cap_done) begin
                    o_cmd.op = ctc_pkg::DP_MUL_INIT;
                    n_state  = ctc_pkg::S_MUL;
                end else begin
                    o_cmd.op = ctc_pkg::DP_STRIP_CAP;
                end
            end
            ctc_pkg::S_MUL: begin
                o_cmd.op = ctc_pkg::DP_MUL_STEP;
                if (i_flags.mul_last) begin
                    n_state = ctc_pkg::S_MUL_END;
                end
            end
            ctc_pkg::S_MUL_END: begin
                o_cmd.op = ctc_pkg::DP_MUL_END;
                if (i_flags.mul_ovf) begin
                    n_code  = ctc_pkg::ST_OVERFLOW;
                    n_state = ctc_pkg::S_FINISH;
                end else if (i_flags.acc_even) begin
                    n_state = ctc_pkg::S_STRIP_CAP;
                end else begin
                    n_state = ctc_pkg::S_SUB;
                end
            end
            ctc_pkg::S_SUB: begin
                o_cmd.op = ctc_pkg::DP_SUB;
                n_state  = ctc_pkg::S_PEAK;
            end
            ctc_pkg::S_PEAK: begin
                o_cmd.op = ctc_pkg::DP_PEAK;
                n_state  = ctc_pkg::S_STRIP;
            end
            ctc_pkg::S_STRIP: begin
                if (i_flags.strip_done) begin
                    n_state = ctc_pkg::S_CMP;
                end else begin
                    o_cmd.op = ctc_pkg::DP_STRIP;
                end
            end
            ctc_pkg::S_CMP: begin
                if (i_flags.below) begin
                    n_code  = ctc_pkg::ST_DONE;
                    n_state = ctc_pkg::S_FINISH;
                end else begin
                    n_state = ctc_pkg::S_ROUND;
                end
            end
            ctc_pkg::S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = ctc_pkg::DP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = ctc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ctc_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// File: hdl/collatz_trajectory_check_top.sv
// Top level of the Collatz trajectory check: configuration register,
// controller and datapath. Depends on ctc_pkg, ctc_ctrl and ctc_dp.
//
// An item is a 128-bit start value given as two 64-bit halves on the input
// channel. For each item one result leaves on the output channel: the peak
// value after the subtract step, the number of rounds started and a status
// code (done, overflow, round limit reached, invalid start).
// The block works on one item at a time. An invalid start is answered without
// running any round. Each round strips up to eight trailing zeros per shift in
// either strip step, and runs a further multiply pass each time more than 40
// zeros come off at once; the multiply by a power of three runs as eight 32x32
// partial products through one multiplier. The time an item takes grows with
// its number of rounds.
// The result is held in an output register, so a new item is accepted while
// the previous result waits. If the receiver stalls, the next item completes
// its work and then waits until the held result is taken.
// Reset clears the controller and the output valid flag and sets round_limit
// to 1000000. round_limit is written at byte address 0; the user must write it
// only while the block is idle, as the block itself does not enforce this.
`default_nettype none
module collatz_trajectory_check_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [63:0] i_start_low,
    input  wire logic [63:0] i_start_high,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_peak_low,
    output logic [63:0]      o_peak_high,
    output logic [31:0]      o_round_count,
    output logic [1:0]       o_status
);

    logic [31:0]         r_round_limit;
    ctc_pkg::t_dp_cmd    cmd;
    ctc_pkg::t_dp_flags  flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_limit <= ctc_pkg::ROUND_LIMIT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == ctc_pkg::REG_ROUND_LIMIT) begin
            r_round_limit <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ctc_pkg::REG_ROUND_LIMIT) ? r_round_limit : 32'd0;

    ctc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_flags     (flags),
        .o_cmd       (cmd)
    );

    ctc_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_round_limit (r_round_limit),
        .i_start_low   (i_start_low),
        .i_start_high  (i_start_high),
        .o_flags       (flags),
        .o_peak_low    (o_peak_low),
        .o_peak_high   (o_peak_high),
        .o_round_count (o_round_count),
        .o_status      (o_status)
    );

endmodule
`default_nettype wire

// File: dv/collatz_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the Collatz trajectory check block: tracks the round
// limit from the APB bus, predicts each result and compares it on arrival.
// Depends on ctc_pkg for the status codes, register index and reset value.
module collatz_result_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic        i_pready,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [63:0] i_start_low,
    input  wire logic [63:0] i_start_high,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [63:0] i_peak_low,
    input  wire logic [63:0] i_peak_high,
    input  wire logic [31:0] i_round_count,
    input  wire logic [1:0]  i_status,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    localparam int SHOWN_LIMIT  = 10;

    typedef struct packed {
        logic [63:0]      peak_low;
        logic [63:0]      peak_high;
        logic [31:0]      rounds;
        ctc_pkg::t_status status;
    } t_trajectory_result;

    t_trajectory_result expected_q [$];
    t_trajectory_result exp_r;
    t_trajectory_result got_r;
    logic [31:0]        limit_copy;
    int                 mismatches_shown;

    function automatic logic [63:0] three_pow(input int e);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < e; i++) p = p * 64'd3;
        return p;
    endfunction

    function automatic int count_tz(input logic [127:0] v);
        int c;
        c = 0;
        if (v == '0) return 128;
        while (!v[c]) c++;
        return c;
    endfunction

    function automatic t_trajectory_result predict_trajectory(input logic [127:0] seed,
                                                              input logic [31:0] limit);
        t_trajectory_result r;
        logic [127:0]       n;
        logic [127:0]       peak;
        logic [191:0]       prod;
        logic [31:0]        rounds;
        logic               busy;
        logic               more;
        logic               ovf;
        int                 a;
        r = '0;
        if (seed == '0 || seed == '1) begin
            r.status = ctc_pkg::ST_INVALID;
            return r;
        end
        n      = seed;
        peak   = '0;
        rounds = '0;
        r.status = ctc_pkg::ST_DONE;
        busy   = 1'b1;
        while (busy) begin
            if (rounds >= limit) begin
                r.status = ctc_pkg::ST_LIMIT;
                busy = 1'b0;
            end else begin
                rounds = rounds + 1;
                n = n + 128'd1;
                if (n == '0) begin
                    r.status = ctc_pkg::ST_OVERFLOW;
                    busy = 1'b0;
                end else begin
                    ovf  = 1'b0;
                    more = 1'b1;
                    while (more) begin
                        a = count_tz(n);
                        if (a > ctc_pkg::POW_CAP) a = ctc_pkg::POW_CAP;
                        n = n >> a;
                        prod = n * three_pow(a);
                        if (prod[191:128] != '0) ovf = 1'b1;
                        else n = prod[127:0];
                        more = !ovf && !n[0];
                    end
                    if (ovf) begin
                        r.status = ctc_pkg::ST_OVERFLOW;
                        busy = 1'b0;
                    end else begin
                        n = n - 128'd1;
                        if (n > peak) peak = n;
                        if (n != '0) n = n >> count_tz(n);
                        if (n < seed) busy = 1'b0;
                    end
                end
            end
        end
        r.peak_low  = peak[63:0];
        r.peak_high = peak[127:64];
        r.rounds    = rounds;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_copy       <= ctc_pkg::ROUND_LIMIT_RESET;
            expected_q.delete();
            o_fail_count     <= 0;
            o_pending        <= 0;
            o_checked        <= 0;
            mismatches_shown = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr == {ctc_pkg::REG_ROUND_LIMIT, 2'b00}) begin
                limit_copy <= i_pwdata;
            end
            if (i_out_valid && i_out_ready) begin
                got_r.peak_low  = i_peak_low;
                got_r.peak_high = i_peak_high;
                got_r.rounds    = i_round_count;
                got_r.status    = ctc_pkg::t_status'(i_status);
                o_checked <= o_checked + 1;
                if (expected_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (mismatches_shown < SHOWN_LIMIT) begin
                        $display("Unexpected result at %0t: peak %h_%h rounds %0d status %0d",
                                 $realtime, i_peak_high, i_peak_low,
                                 i_round_count, i_status);
                    end
                    mismatches_shown++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got_r !== exp_r) begin
                        o_fail_count <= o_fail_count + 1;
                        if (mismatches_shown < SHOWN_LIMIT) begin
                            $display({"Mismatch on result %0d: expected peak %h_%h",
                                      " rounds %0d status %0d"},
                                     o_checked, exp_r.peak_high, exp_r.peak_low,
                                     exp_r.rounds, exp_r.status);
                            $display("    got peak %h_%h rounds %0d status %0d",
                                     got_r.peak_high, got_r.peak_low, got_r.rounds, i_status);
                        end
                        mismatches_shown++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_q.push_back(predict_trajectory({i_start_high, i_start_low},
                                                        limit_copy));
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

// File: dv/collatz_trajectory_check_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the Collatz trajectory check block: drives start values
// and round-limit writes with random idling and gives the verdict.
// Depends on ctc_pkg, collatz_trajectory_check_top and collatz_result_checker.
module collatz_trajectory_check_top_tb;

    localparam logic [2:0] ADDR_ROUND_LIMIT = {ctc_pkg::REG_ROUND_LIMIT, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED    = {~ctc_pkg::REG_ROUND_LIMIT, 2'b00};
    localparam int         QUIET_LIMIT      = 200000;
    localparam int         END_SETTLE       = 40;
    localparam int         DIRECTED_COUNT   = 19;

    localparam logic [127:0] DIRECTED_STARTS [DIRECTED_COUNT] = '{
        128'd0,
        {128{1'b1}},
        128'd3,
        128'd7,
        128'd27,
        128'd2,
        128'd1 << 127,
        {128{1'b1}} - 128'd1,
        {128{1'b1}} - 128'd2,
        (128'd1 << 50) - 128'd1,
        (128'd1 << 80) - 128'd1,
        (128'd1 << 81) - 128'd1,
        (128'd1 << 100) - 128'd1,
        (128'd1 << 127) - 128'd1,
        (128'd1 << 64) - 128'd1,
        (128'd1 << 64) + 128'd1,
        {{64{1'b1}}, 64'd0},
        {{64{1'b1}}, 64'd1},
        {64{2'b01}}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [63:0] i_start_low;
    logic [63:0] i_start_high;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_peak_low;
    logic [63:0] o_peak_high;
    logic [31:0] o_round_count;
    logic [1:0]  o_status;

    int          fail_count;
    int          pending;
    int          checked;
    int          quiet_cycles;
    int          items_sent;
    int          settings_used;
    logic [31:0] limit_now;

    collatz_trajectory_check_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_start_low   (i_start_low),
        .i_start_high  (i_start_high),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_peak_low    (o_peak_low),
        .o_peak_high   (o_peak_high),
        .o_round_count (o_round_count),
        .o_status      (o_status)
    );

    collatz_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_start_low   (i_start_low),
        .i_start_high  (i_start_high),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_peak_low    (o_peak_low),
        .i_peak_high   (o_peak_high),
        .i_round_count (o_round_count),
        .i_status      (o_status),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 30);
        return $urandom_range(60, 300);
    endfunction

    function automatic logic [127:0] random_start();
        logic [127:0] v;
        int           pick;
        int           w;
        v    = {$urandom, $urandom, $urandom, $urandom};
        pick = $urandom_range(0, 99);
        w    = $urandom_range(1, 127);
        if (pick < 40) begin
            v = (v & ((128'd1 << $urandom_range(2, 100)) - 128'd1)) | 128'd1;
        end else if (pick < 60) begin
            v[0] = 1'b1;
        end else if (pick < 80) begin
            if (pick < 70) v = (v << w) | ((128'd1 << w) - 128'd1);
            else v = (128'd1 << w) - 128'd1;
        end else if (pick < 88) begin
            v[127:64] = '1;
        end else if (pick < 94) begin
            v = ($urandom_range(0, 1) == 0) ? '0 : '1;
        end else begin
            v = v << w;
        end
        return v;
    endfunction

    task automatic send_start(input logic [127:0] v, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_start_low  <= v[63:0];
        i_start_high <= v[127:64];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic quiesce();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending == 0);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_round_limit(input logic [31:0] value);
        quiesce();
        apb_write(ADDR_ROUND_LIMIT, value);
        limit_now = value;
        settings_used++;
    endtask

    task automatic random_phase(input int count);
        logic [127:0] v;
        int           gap;
        for (int k = 0; k < count; k++) begin
            v = random_start();
            // A start of one never drops below itself, so only the limit ends it.
            if (v == 128'd1 && limit_now > 32'd64) v = 128'd5;
            gap = ((k / 64) % 3 == 2) ? 0 : pick_gap();
            if (k % 150 == 149) quiesce();
            send_start(v, gap);
        end
    endtask

    initial begin : drain_side
        int hold;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            hold = ($urandom_range(0, 19) == 0) ? $urandom_range(300, 1500)
                                                : $urandom_range(1, 40);
            repeat (hold) begin
                @(negedge i_clk);
                i_out_ready <= 1'b1;
            end
            hold = pick_gap();
            repeat (hold) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_start_low   = '0;
        i_start_high  = '0;
        items_sent    = 0;
        settings_used = 1;
        limit_now     = ctc_pkg::ROUND_LIMIT_RESET;
        quiet_cycles  = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_COUNT; k++) send_start(DIRECTED_STARTS[k], pick_gap());

        set_round_limit(32'd1);
        send_start(128'd7, 0);
        send_start(128'd3, 0);
        send_start(128'd1, 0);
        send_start(128'd2, 2);
        random_phase(150);

        quiesce();
        apb_write(ADDR_UNMAPPED, $urandom);
        random_phase(50);

        set_round_limit(32'hFFFF_FFFF);
        random_phase(350);

        set_round_limit($urandom_range(2, 12));
        random_phase(300);

        set_round_limit($urandom_range(1000, 1000000));
        random_phase(330);

        quiesce();
        repeat (END_SETTLE) @(posedge i_clk);
        $display("Summary: %0d start values sent under %0d round-limit settings.",
                 items_sent, settings_used);
        $display("Summary: %0d results checked, %0d disagreed with the prediction.",
                 checked, fail_count);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/ctc_pkg.sv
hdl/ctc_dp.sv
hdl/ctc_ctrl.sv
hdl/collatz_trajectory_check_top.sv
dv/collatz_result_checker.sv
dv/collatz_trajectory_check_top_tb.sv
